@@ src/srb_pkg.sv @@
// Shared constants and operation codes for the serial ring buffer core.
`default_nettype none
package srb_pkg;

   localparam int RX_DEPTH = 128;
   localparam int TX_DEPTH = 32;
   localparam int RX_AW    = $clog2(RX_DEPTH);
   localparam int TX_AW    = $clog2(TX_DEPTH);

   localparam int DATA_W     = 8;
   localparam int LEVEL_W    = 7;
   localparam int RX_FILL_W  = 7;
   localparam int TX_FILL_W  = 5;
   localparam int COUNT_W    = 8;
   localparam int OP_W       = 3;
   localparam int FLOW_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;
   localparam int CMP_W      = (RX_AW > LEVEL_W) ? RX_AW : LEVEL_W;

   localparam logic [OP_W-1:0] OP_RX_BYTE = 3'd0;
   localparam logic [OP_W-1:0] OP_READ    = 3'd1;
   localparam logic [OP_W-1:0] OP_PEEK    = 3'd2;
   localparam logic [OP_W-1:0] OP_WRITE   = 3'd3;
   localparam logic [OP_W-1:0] OP_TX_SLOT = 3'd4;
   localparam logic [OP_W-1:0] OP_FLUSH   = 3'd5;
   localparam logic [OP_W-1:0] OP_ERROR   = 3'd6;

   localparam logic [FLOW_W-1:0] FS_XON_SENT  = 2'd0;
   localparam logic [FLOW_W-1:0] FS_XON_OWED  = 2'd1;
   localparam logic [FLOW_W-1:0] FS_XOFF_OWED = 2'd2;
   localparam logic [FLOW_W-1:0] FS_XOFF_SENT = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_FLOW_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_XOFF_LEVEL  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_XON_LEVEL   = 2'd2;

   localparam logic [DATA_W-1:0] FLOW_RESUME_BYTE = 8'h11;
   localparam logic [DATA_W-1:0] FLOW_PAUSE_BYTE  = 8'h13;

   localparam logic [1:0] TXS_NONE = 2'd0;
   localparam logic [1:0] TXS_XON  = 2'd1;
   localparam logic [1:0] TXS_XOFF = 2'd2;
   localparam logic [1:0] TXS_RING = 2'd3;

endpackage
`default_nettype wire

@@ src/srb_ram.sv @@
// Single-port-write, single-port-read synchronous RAM with registered read data.
`default_nettype none
module srb_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ src/serial_ring_buffers_xon_xoff_core.sv @@
// Top level of the serial ring buffer core with XON/XOFF flow control.
//
// Each transaction on the request channel is one event (received byte, read, peek, write,
// transmitter slot, receive flush or error report) and produces exactly one registered
// response transaction. Ring pointers, counters and the flow state are updated at
// the accepting edge, while a read or peek reads the receive RAM and a transmitter slot
// reads the transmit RAM at that same edge; the RAM's registered read data forms the
// response. The response register is freed by the same edge that takes its contents, so
// the core sustains one event per cycle when the response side is always ready.
`default_nettype none
module serial_ring_buffers_xon_xoff_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [srb_pkg::OP_W-1:0]       req_op,
   input  wire logic [srb_pkg::DATA_W-1:0]     req_data,
   input  wire logic                           req_overrun,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic      [srb_pkg::DATA_W-1:0]     rsp_read_data,
   output logic                                rsp_read_valid,
   output logic      [srb_pkg::DATA_W-1:0]     rsp_tx_byte,
   output logic                                rsp_tx_valid,
   output logic                                rsp_write_accepted,
   output logic      [srb_pkg::RX_FILL_W-1:0]  rsp_rx_fill,
   output logic      [srb_pkg::TX_FILL_W-1:0]  rsp_tx_fill,
   output logic      [srb_pkg::COUNT_W-1:0]    rsp_dropped_total,
   output logic      [srb_pkg::COUNT_W-1:0]    rsp_overrun_total,
   output logic      [srb_pkg::RX_FILL_W-1:0]  rsp_peak_fill,
   output logic      [srb_pkg::FLOW_W-1:0]     rsp_flow_status,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [srb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [srb_pkg::CSR_DATA_W-1:0] csr_wdata
);

   import srb_pkg::*;

   logic                 flow_enable_ff;
   logic [LEVEL_W-1:0]   xoff_level_ff;
   logic [LEVEL_W-1:0]   xon_level_ff;

   logic [RX_AW-1:0]     rx_head_ff, rx_head_in;
   logic [RX_AW-1:0]     rx_tail_ff, rx_tail_in;
   logic [TX_AW-1:0]     tx_head_ff, tx_head_in;
   logic [TX_AW-1:0]     tx_tail_ff, tx_tail_in;
   logic [FLOW_W-1:0]    flow_ff, flow_in;
   logic [COUNT_W-1:0]   dropped_ff, dropped_in;
   logic [COUNT_W-1:0]   overrun_ff, overrun_in;
   logic [RX_AW-1:0]     peak_ff, peak_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic [1:0]           tx_src_ff, tx_src_in;
   logic                 wacc_ff, wacc_in;

   logic                 accept;
   logic [RX_AW-1:0]     rx_fill;
   logic [RX_AW-1:0]     rx_fill_after;
   logic                 rx_full;
   logic                 rx_empty;
   logic                 tx_full;
   logic                 tx_empty;
   logic                 xoff_side;
   logic                 xon_side;

   logic                 rx_wr_en;
   logic                 rx_rd_en;
   logic                 tx_wr_en;
   logic                 tx_rd_en;
   logic [DATA_W-1:0]    rx_rd_data;
   logic [DATA_W-1:0]    tx_rd_data;

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;

   assign rx_fill   = rx_head_ff - rx_tail_ff;
   assign rx_full   = (rx_head_ff + RX_AW'(1)) == rx_tail_ff;
   assign rx_empty  = rx_head_ff == rx_tail_ff;
   assign tx_full   = (tx_head_ff + TX_AW'(1)) == tx_tail_ff;
   assign tx_empty  = tx_head_ff == tx_tail_ff;
   assign xon_side  = (flow_ff == FS_XON_SENT) || (flow_ff == FS_XON_OWED);
   assign xoff_side = (flow_ff == FS_XOFF_OWED) || (flow_ff == FS_XOFF_SENT);

   always_comb begin
      rx_head_in    = rx_head_ff;
      rx_tail_in    = rx_tail_ff;
      tx_head_in    = tx_head_ff;
      tx_tail_in    = tx_tail_ff;
      flow_in       = flow_ff;
      dropped_in    = dropped_ff;
      overrun_in    = overrun_ff;
      peak_in       = peak_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rd_valid_in   = rd_valid_ff;
      tx_src_in     = tx_src_ff;
      wacc_in       = wacc_ff;
      rx_wr_en      = 1'b0;
      rx_rd_en      = 1'b0;
      tx_wr_en      = 1'b0;
      tx_rd_en      = 1'b0;
      rx_fill_after = rx_fill;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rd_valid_in  = 1'b0;
         tx_src_in    = TXS_NONE;
         wacc_in      = 1'b0;
         case (req_op)
            OP_RX_BYTE: begin
               if (!rx_full) begin
                  rx_wr_en      = 1'b1;
                  rx_head_in    = rx_head_ff + RX_AW'(1);
                  rx_fill_after = rx_fill + RX_AW'(1);
               end else if (dropped_ff != '1) begin
                  dropped_in = dropped_ff + COUNT_W'(1);
               end
               if (rx_fill_after > peak_ff) begin
                  peak_in = rx_fill_after;
               end
               if (flow_enable_ff && xon_side &&
                   (CMP_W'(rx_fill_after) >= CMP_W'(xoff_level_ff))) begin
                  flow_in = FS_XOFF_OWED;
               end
            end
            OP_READ: begin
               if (!rx_empty) begin
                  rx_rd_en      = 1'b1;
                  rd_valid_in   = 1'b1;
                  rx_tail_in    = rx_tail_ff + RX_AW'(1);
                  rx_fill_after = rx_fill - RX_AW'(1);
                  if (flow_enable_ff && xoff_side &&
                      (CMP_W'(rx_fill_after) < CMP_W'(xon_level_ff))) begin
                     flow_in = FS_XON_OWED;
                  end
               end
            end
            OP_PEEK: begin
               if (!rx_empty) begin
                  rx_rd_en    = 1'b1;
                  rd_valid_in = 1'b1;
               end
            end
            OP_WRITE: begin
               if (!tx_full) begin
                  tx_wr_en   = 1'b1;
                  tx_head_in = tx_head_ff + TX_AW'(1);
                  wacc_in    = 1'b1;
               end
            end
            OP_TX_SLOT: begin
               if (flow_ff == FS_XON_OWED) begin
                  tx_src_in = TXS_XON;
                  flow_in   = FS_XON_SENT;
               end else if (flow_ff == FS_XOFF_OWED) begin
                  tx_src_in = TXS_XOFF;
                  flow_in   = FS_XOFF_SENT;
               end else if (!tx_empty) begin
                  tx_src_in  = TXS_RING;
                  tx_rd_en   = 1'b1;
                  tx_tail_in = tx_tail_ff + TX_AW'(1);
               end
            end
            OP_FLUSH: begin
               rx_tail_in = rx_head_ff;
               if (flow_enable_ff && xoff_side) begin
                  flow_in = FS_XON_OWED;
               end
            end
            OP_ERROR: begin
               if (req_overrun) begin
                  if (dropped_ff != '1) begin
                     dropped_in = dropped_ff + COUNT_W'(1);
                  end
                  if (overrun_ff != '1) begin
                     overrun_in = overrun_ff + COUNT_W'(1);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_head_ff   <= '0;
         rx_tail_ff   <= '0;
         tx_head_ff   <= '0;
         tx_tail_ff   <= '0;
         flow_ff      <= FS_XON_SENT;
         dropped_ff   <= '0;
         overrun_ff   <= '0;
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
         tx_src_ff    <= TXS_NONE;
         wacc_ff      <= 1'b0;
      end else begin
         rx_head_ff   <= rx_head_in;
         rx_tail_ff   <= rx_tail_in;
         tx_head_ff   <= tx_head_in;
         tx_tail_ff   <= tx_tail_in;
         flow_ff      <= flow_in;
         dropped_ff   <= dropped_in;
         overrun_ff   <= overrun_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_valid_ff  <= rd_valid_in;
         tx_src_ff    <= tx_src_in;
         wacc_ff      <= wacc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flow_enable_ff <= 1'b1;
         xoff_level_ff  <= LEVEL_W'(16);
         xon_level_ff   <= LEVEL_W'(12);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FLOW_ENABLE: flow_enable_ff <= csr_wdata[0];
            CSR_XOFF_LEVEL:  xoff_level_ff  <= LEVEL_W'(csr_wdata);
            CSR_XON_LEVEL:   xon_level_ff   <= LEVEL_W'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   srb_ram #(
      .DEPTH (RX_DEPTH),
      .WIDTH (DATA_W)
   ) u_rx_ram (
      .clock   (clock),
      .wr_en   (rx_wr_en),
      .wr_addr (rx_head_ff),
      .wr_data (req_data),
      .rd_en   (rx_rd_en),
      .rd_addr (rx_tail_ff),
      .rd_data (rx_rd_data)
   );

   srb_ram #(
      .DEPTH (TX_DEPTH),
      .WIDTH (DATA_W)
   ) u_tx_ram (
      .clock   (clock),
      .wr_en   (tx_wr_en),
      .wr_addr (tx_head_ff),
      .wr_data (req_data),
      .rd_en   (tx_rd_en),
      .rd_addr (tx_tail_ff),
      .rd_data (tx_rd_data)
   );

   always_comb begin
      case (tx_src_ff)
         TXS_XON:  rsp_tx_byte = FLOW_RESUME_BYTE;
         TXS_XOFF: rsp_tx_byte = FLOW_PAUSE_BYTE;
         TXS_RING: rsp_tx_byte = tx_rd_data;
         default:  rsp_tx_byte = '0;
      endcase
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_valid     = rd_valid_ff;
   assign rsp_read_data      = rd_valid_ff ? rx_rd_data : '0;
   assign rsp_tx_valid       = tx_src_ff != TXS_NONE;
   assign rsp_write_accepted = wacc_ff;
   assign rsp_rx_fill        = RX_FILL_W'(rx_fill);
   assign rsp_tx_fill        = TX_FILL_W'(tx_head_ff - tx_tail_ff);
   assign rsp_dropped_total  = dropped_ff;
   assign rsp_overrun_total  = overrun_ff;
   assign rsp_peak_fill      = RX_FILL_W'(peak_ff);
   assign rsp_flow_status    = flow_ff;

   a_flush_empties: assert property (@(posedge clock) disable iff (reset)
      (accept && req_op == OP_FLUSH) |=> (rsp_rx_fill == '0))
      else $error("receive ring not empty after flush");

   a_xon_first: assert property (@(posedge clock) disable iff (reset)
      (accept && req_op == OP_TX_SLOT && flow_ff == FS_XON_OWED)
      |=> (rsp_tx_valid && rsp_tx_byte == FLOW_RESUME_BYTE &&
           rsp_flow_status == FS_XON_SENT))
      else $error("owed XON not sent first");

   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_tx_valid && rsp_read_valid))
      else $error("response carries both read and transmit data");

   a_write_fill: assert property (@(posedge clock) disable iff (reset)
      (accept && req_op == OP_WRITE && !tx_full)
      |=> (rsp_write_accepted && rsp_tx_fill == TX_FILL_W'($past(rsp_tx_fill) + 1'b1)))
      else $error("accepted write did not grow transmit fill");

endmodule
`default_nettype wire
